[rtl/kmd_pkg.sv]
// Package for the key matrix debouncer: key counts, widths, register
// indexes and the flip-count function. No dependencies.
`default_nettype none

package kmd_pkg;

    localparam int DIRECT_KEYS  = 5;
    localparam int MATRIX_ROWS  = 5;
    localparam int MATRIX_COLS  = 5;
    localparam int MATRIX_KEYS  = MATRIX_ROWS * MATRIX_COLS;
    localparam int TOTAL_KEYS   = DIRECT_KEYS + MATRIX_KEYS;
    localparam int COUNTER_BITS = 8;
    localparam int THRESH_W     = 8;
    localparam int CMP_W        = (COUNTER_BITS > THRESH_W) ? COUNTER_BITS : THRESH_W;
    localparam int COUNT_W      = $clog2(TOTAL_KEYS + 1);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = CFG_IDX_W'(1);

    localparam logic [THRESH_W-1:0]    THRESH_RESET = THRESH_W'(10);
    localparam logic [DIRECT_KEYS-1:0] INVERT_RESET = DIRECT_KEYS'(3);

    localparam logic [COUNTER_BITS-1:0] COUNTER_TOP = {COUNTER_BITS{1'b1}};

    typedef logic [TOTAL_KEYS-1:0] t_key_vec;

    // Number of set bits in a key vector, summed as a pairwise tree.
    function automatic logic [COUNT_W-1:0] flip_count(input t_key_vec v);
        logic [COUNT_W-1:0] sums [TOTAL_KEYS];
        for (int k = 0; k < TOTAL_KEYS; k++) begin
            sums[k] = COUNT_W'(v[k]);
        end
        for (int step = 1; step < TOTAL_KEYS; step = step * 2) begin
            for (int k = 0; k + step < TOTAL_KEYS; k = k + 2 * step) begin
                sums[k] = sums[k] + sums[k + step];
            end
        end
        return sums[0];
    endfunction

endpackage

`default_nettype wire

[rtl/kmd_lane.sv]
// One debounce lane: debounced state and saturating run counter of a
// single key. Depends on kmd_pkg.
`default_nettype none

module kmd_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_sample,
    input  wire logic [kmd_pkg::THRESH_W-1:0] i_threshold,
    output logic                              o_state_next,
    output logic                              o_flip
);
    import kmd_pkg::*;

    logic                    r_state;
    logic [COUNTER_BITS-1:0] r_count;
    logic                    n_state;
    logic [COUNTER_BITS-1:0] n_count;
    logic                    differs;
    logic                    over;

    assign differs = (i_sample != r_state);
    assign over    = CMP_W'(r_count) > CMP_W'(i_threshold);
    assign o_flip  = differs && over;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        if (!differs) begin
            n_count = '0;
        end else if (over) begin
            n_state = i_sample;
            n_count = '0;
        end else if (r_count != COUNTER_TOP) begin
            n_count = r_count + COUNTER_BITS'(1);
        end
    end

    assign o_state_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_flip_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_flip |=> r_count == '0 && r_state != $past(r_state))
        else $error("lane flip did not clear counter or toggle state");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_state) && $stable(r_count))
        else $error("lane state moved without an accepted item");
    a_agree_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_sample == r_state |=> r_count == '0)
        else $error("agreeing sample did not clear counter");
`endif

endmodule

`default_nettype wire

[rtl/kmd_merge.sv]
// Merge stage: counts lane flips and holds the result item in an output
// register with stall handling. Depends on kmd_pkg.
`default_nettype none

module kmd_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire kmd_pkg::t_key_vec           i_states,
    input  wire kmd_pkg::t_key_vec           i_flips,
    input  wire logic                        i_stall,
    output logic                             o_valid,
    output logic                             o_busy,
    output kmd_pkg::t_key_vec                o_key_states,
    output logic [kmd_pkg::COUNT_W-1:0]      o_change_count
);
    import kmd_pkg::*;

    logic               r_valid;
    t_key_vec           r_states;
    logic [COUNT_W-1:0] r_count;

    // a new item may enter when no result is held or the held result leaves this cycle
    assign o_busy = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_states <= i_states;
            r_count  <= flip_count(i_flips);
        end
    end

    assign o_valid        = r_valid;
    assign o_key_states   = r_states;
    assign o_change_count = r_count;

`ifndef ASSERT_OFF
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_valid && r_states == $past(i_states))
        else $error("accepted item not presented");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_count <= COUNT_W'(TOTAL_KEYS))
        else $error("change count out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |-> !i_accept)
        else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

[rtl/key_matrix_debouncer_top.sv]
// Key matrix debouncer top level: configuration registers, one debounce
// lane per key and the merge stage. Depends on kmd_pkg, kmd_lane, kmd_merge.
//
// Each accepted item is one scan snapshot of 5 direct buttons and 25 matrix
// keys (bit col*5+row). Every key has its own lane, so all keys update in the
// cycle the item is accepted and its result (30 debounced states and the
// number of keys that flipped) appears in the output register. One item is
// taken per clock unless stalled; the output register is the only stage, and
// a new item is taken in the same cycle a held result leaves. A key flips on
// a differing sample once its run counter already exceeds the threshold; the
// counter saturates at its top value. Direct levels are XORed with the invert
// mask first. Write configuration only while no item is in flight.
`default_nettype none

module key_matrix_debouncer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [kmd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [kmd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [kmd_pkg::DIRECT_KEYS-1:0]  i_direct_levels,
    input  wire logic [kmd_pkg::MATRIX_KEYS-1:0]  i_matrix_levels,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [kmd_pkg::TOTAL_KEYS-1:0]        o_key_states,
    output logic [kmd_pkg::COUNT_W-1:0]           o_change_count
);
    import kmd_pkg::*;

    logic [THRESH_W-1:0]    r_threshold;
    logic [DIRECT_KEYS-1:0] r_invert;
    logic                   accept;
    logic                   busy;
    t_key_vec               samples;
    t_key_vec               states_next;
    t_key_vec               flips;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_invert    <= INVERT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= THRESH_W'(i_cfg_data);
                CFG_INVERT:    r_invert    <= DIRECT_KEYS'(i_cfg_data);
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_stall = busy;
    assign accept  = i_valid && !busy;
    assign samples = {i_matrix_levels, i_direct_levels ^ r_invert};

    for (genvar k = 0; k < TOTAL_KEYS; k++) begin : g_lane
        kmd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (accept),
            .i_sample     (samples[k]),
            .i_threshold  (r_threshold),
            .o_state_next (states_next[k]),
            .o_flip       (flips[k])
        );
    end

    kmd_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_states       (states_next),
        .i_flips        (flips),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_busy         (busy),
        .o_key_states   (o_key_states),
        .o_change_count (o_change_count)
    );

`ifndef ASSERT_OFF
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");
    a_no_flip_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && flips == '0 |=> o_change_count == '0)
        else $error("change count without flips");
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> $stable(r_threshold) && $stable(r_invert))
        else $error("configuration changed without a write");
`endif

endmodule

`default_nettype wire

[tb/sv/key_matrix_debouncer_top_test.sv]
// Self-checking testbench for key_matrix_debouncer_top: a short scripted
// sequence, then randomized scan snapshots over several register settings.
// Depends on kmd_pkg and the key_matrix_debouncer_top RTL.
`timescale 1ns / 100ps

module key_matrix_debouncer_top_test;

    import kmd_pkg::*;

    localparam int DK = DIRECT_KEYS;
    localparam int MK = MATRIX_KEYS;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int LONG_HOLD    = 270;

    typedef enum logic [1:0] {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    typedef struct packed {
        t_key_vec           states;
        logic [COUNT_W-1:0] flips;
    } t_scan_result;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [DK-1:0]         direct;
        logic [MK-1:0]         matrix;
        logic                  typed;
        t_key_vec              exp_states;
        logic [COUNT_W-1:0]    exp_flips;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [DK-1:0]         i_direct_levels;
    logic [MK-1:0]         i_matrix_levels;
    logic                  o_valid;
    logic                  i_stall;
    t_key_vec              o_key_states;
    logic [COUNT_W-1:0]    o_change_count;

    key_matrix_debouncer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_direct_levels (i_direct_levels),
        .i_matrix_levels (i_matrix_levels),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_key_states    (o_key_states),
        .o_change_count  (o_change_count)
    );

    // Predictor state: debounced level and run length of every key.
    t_key_vec              key_level;
    logic [COUNTER_BITS-1:0] run_len [TOTAL_KEYS];
    logic [THRESH_W-1:0]   cur_threshold;
    logic [DK-1:0]         cur_invert;

    t_scan_result pending_scans [$];
    t_idle_mode   idle_mode;
    int           mismatches;
    int           cycle_count;

    // Scripted part: writes, extremes and a few bounce patterns.
    t_script_row script_rows [0:29] = '{
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h00, 25'h0000000, 1'b1, 30'h00000000, 5'd0},
        '{1'b1, CFG_SPARE_A,   8'hFF, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_SPARE_B,   8'h00, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_THRESHOLD, 8'h00, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h00, 25'h0000000, 1'b1, 30'h00000003, 5'd2},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h1FFFFFF, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h1FFFFFF, 1'b1, 30'h3FFFFFFC, 5'd30},
        '{1'b1, CFG_INVERT,    8'h1F, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h1FFFFFF, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h1FFFFFF, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_INVERT,    8'hE0, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_THRESHOLD, 8'hFE, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h10, 25'h0000001, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h01, 25'h1000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_THRESHOLD, 8'hFF, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h1FFFFFF, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h1FFFFFF, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_THRESHOLD, 8'h01, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b1, CFG_INVERT,    8'h15, 5'h00, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h0A, 25'h1555555, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h15, 25'h0AAAAAA, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h15, 25'h0AAAAAA, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h15, 25'h0AAAAAA, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h0A, 25'h1555555, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h0A, 25'h1555555, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h0A, 25'h1555555, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h1F, 25'h0000000, 1'b0, 30'h00000000, 5'd0},
        '{1'b0, CFG_THRESHOLD, 8'h00, 5'h00, 25'h1FFFFFF, 1'b0, 30'h00000000, 5'd0}
    };

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Advance every key by one snapshot; returns the states and flip count.
    function automatic t_scan_result debounce_scan(input logic [DK-1:0] direct,
                                                   input logic [MK-1:0] matrix);
        t_scan_result       res;
        t_key_vec           samples;
        logic [COUNT_W-1:0] flips;
        samples = {matrix, direct ^ cur_invert};
        flips   = '0;
        for (int k = 0; k < TOTAL_KEYS; k++) begin
            if (samples[k] != key_level[k]) begin
                if (run_len[k] > cur_threshold) begin
                    key_level[k] = samples[k];
                    run_len[k]   = '0;
                    flips        = flips + 1'b1;
                end else if (run_len[k] != COUNTER_TOP) begin
                    run_len[k] = run_len[k] + 1'b1;
                end
            end else begin
                run_len[k] = '0;
            end
        end
        res.states = key_level;
        res.flips  = flips;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Present one snapshot and hold it until accepted.
    task automatic push_snapshot(input logic [DK-1:0] direct, input logic [MK-1:0] matrix,
                                 input logic given, input t_scan_result given_res);
        t_scan_result pred;
        int           tx_pct;
        tx_pct = (idle_mode == IDLE_RX_HEAVY) ? 13 : (idle_mode == IDLE_TX_HEAVY) ? 84 : 0;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_direct_levels <= direct;
        i_matrix_levels <= matrix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = debounce_scan(direct, matrix);
        pending_scans.push_back(given ? given_res : pred);
    endtask

    // Drop valid and wait until every result is back.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_THRESHOLD) begin
            cur_threshold = data[THRESH_W-1:0];
        end else if (idx == CFG_INVERT) begin
            cur_invert = data[DK-1:0];
        end
    endtask

    // Result side: check each accepted result and stall at random.
    always @(posedge i_clk) begin : result_check
        t_scan_result want;
        int           rx_pct;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("key_matrix_debouncer_top regression: fail");
            $finish;
        end else begin
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_scans.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_key_states), 32'(o_change_count));
                end else begin
                    want = pending_scans.pop_front();
                    if (o_key_states !== want.states)
                        report_mismatch("key_states", 32'(o_key_states), 32'(want.states));
                    if (o_change_count !== want.flips)
                        report_mismatch("change_count", 32'(o_change_count), 32'(want.flips));
                end
            end
            rx_pct = (idle_mode == IDLE_RX_HEAVY) ? 84 : (idle_mode == IDLE_TX_HEAVY) ? 13 : 0;
            i_stall <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    initial begin : stimulus
        logic [THRESH_W-1:0] phase_thresh [PHASES];
        t_script_row         row;
        t_scan_result        typed_res;
        logic [DK-1:0]       tgt_direct, direct;
        logic [MK-1:0]       tgt_matrix, matrix;
        logic [DK-1:0]       inv;
        int                  remaining, hold, pos, span;

        phase_thresh = '{8'd0, 8'd2, 8'd6, 8'd254, 8'd12, 8'd1, 8'd255, 8'd4};
        mismatches   = 0;
        cycle_count  = 0;
        idle_mode    = IDLE_RX_HEAVY;
        key_level     = '0;
        for (int k = 0; k < TOTAL_KEYS; k++) run_len[k] = '0;
        cur_threshold = THRESH_RESET;
        cur_invert    = INVERT_RESET;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_THRESHOLD;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_direct_levels <= '0;
        i_matrix_levels <= '0;
        i_stall         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[r]) begin
            row = script_rows[r];
            if (row.is_write) begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                typed_res.states = row.exp_states;
                typed_res.flips  = row.exp_flips;
                push_snapshot(row.direct, row.matrix, row.typed, typed_res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            idle_mode = (p < 3) ? IDLE_RX_HEAVY : (p < 6) ? IDLE_TX_HEAVY : IDLE_NONE;
            inv = (p == 0) ? '0 : (p == 1) ? '1 : DK'($urandom_range(0, 31));
            write_reg(CFG_THRESHOLD, phase_thresh[p]);
            write_reg(CFG_INVERT, {3'($urandom()), inv});
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom()));

            // High thresholds need one long steady run to reach the counter top.
            if (phase_thresh[p] >= 8'd200) begin
                tgt_direct = DK'($urandom());
                tgt_matrix = MK'($urandom());
                for (int i = 0; i < LONG_HOLD; i++)
                    push_snapshot(tgt_direct, tgt_matrix, 1'b0, typed_res);
            end

            span = (phase_thresh[p] > 8'd20) ? 26 : int'(phase_thresh[p]) + 6;
            remaining = PHASE_ITEMS;
            while (remaining > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_snapshot(DK'($urandom()), MK'($urandom()), 1'b0, typed_res);
                    remaining--;
                end else begin
                    tgt_direct = DK'($urandom());
                    tgt_matrix = MK'($urandom());
                    hold = $urandom_range(1, span);
                    for (int i = 0; i < hold; i++) begin
                        direct = tgt_direct;
                        matrix = tgt_matrix;
                        // Bounce one contact now and then.
                        if ($urandom_range(0, 7) == 0) begin
                            pos = $urandom_range(0, TOTAL_KEYS - 1);
                            if (pos < DK) direct[pos] = ~direct[pos];
                            else matrix[pos - DK] = ~matrix[pos - DK];
                        end
                        push_snapshot(direct, matrix, 1'b0, typed_res);
                    end
                    remaining -= hold;
                end
            end
        end

        i_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("key_matrix_debouncer_top regression: pass");
        end else begin
            $display("key_matrix_debouncer_top regression: fail");
        end
        $finish;
    end

endmodule
